// ===== rtl/ili_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ili_pkg
// Shared types, command and result codes for the interval list intersector.
// ----------------------------------------------------------------------------
package ili_pkg;

	localparam int LIST_DEPTH_DEF = 16;
	localparam int TIME_WIDTH_DEF = 16;
	localparam int FIELD_W        = 16;
	localparam int EXT_W          = 32;

	localparam logic [1:0] CMD_APPEND_A  = 2'd0;
	localparam logic [1:0] CMD_APPEND_B  = 2'd1;
	localparam logic [1:0] CMD_INTERSECT = 2'd2;
	localparam logic [1:0] CMD_CLEAR     = 2'd3;

	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_FULL   = 2'd1;
	localparam logic [1:0] KIND_ISECT  = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [FIELD_W-1:0] start_time;
		logic [FIELD_W-1:0] end_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [FIELD_W-1:0] out_start;
		logic [FIELD_W-1:0] out_end;
		logic               last;
	} out_item_t;

endpackage

// ===== rtl/interval_list_intersect_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_list_intersect_top
// Append, clear and two-pointer intersection of two interval lists kept in
// two synchronous single-port-read memories.
// Append and clear give their result beat in the cycle after start;
// a new command may be taken every cycle for these.
// Intersect: each walk step is a memory read, then compare and advance,
// at most countA + countB - 1 steps, then the final beat.
// Reset clears both counts; list memories hold garbage until written.
// Results cannot be stalled: each beat shows on strobe for one cycle.
// ----------------------------------------------------------------------------
module interval_list_intersect_top
	import ili_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF,
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      strobe,
	output out_item_t result
);

	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int ENT_W = 2 * TIME_WIDTH;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_END  = 2'd3;

	logic [ENT_W-1:0] mem_a [LIST_DEPTH];
	logic [ENT_W-1:0] mem_b [LIST_DEPTH];
	logic [ENT_W-1:0] rd_a_q, rd_b_q;

	logic [1:0]            state_q, state_d;
	logic [CNT_W-1:0]      cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
	logic [CNT_W-1:0]      ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
	logic                  pend_vld_q, pend_vld_d;
	logic [TIME_WIDTH-1:0] pend_lo_q, pend_lo_d, pend_hi_q, pend_hi_d;
	logic                  strobe_q, strobe_d;
	out_item_t             result_q, result_d;
	logic                  wr_a, wr_b, accept;

	logic [EXT_W-1:0]      s_ext, e_ext, pend_lo_ext, pend_hi_ext;
	logic [ENT_W-1:0]      wdata;
	logic [TIME_WIDTH-1:0] a_lo, a_hi, b_lo, b_hi, lo, hi;
	logic [CNT_W-1:0]      ptr_a_inc, ptr_b_inc;

	assign accept      = start && !busy;
	assign busy        = (state_q != ST_IDLE);
	assign strobe      = strobe_q;
	assign result      = result_q;

	assign s_ext       = EXT_W'(item.start_time);
	assign e_ext       = EXT_W'(item.end_time);
	assign wdata       = {s_ext[TIME_WIDTH-1:0], e_ext[TIME_WIDTH-1:0]};
	assign pend_lo_ext = EXT_W'(pend_lo_q);
	assign pend_hi_ext = EXT_W'(pend_hi_q);

	assign a_lo = rd_a_q[ENT_W-1:TIME_WIDTH];
	assign a_hi = rd_a_q[TIME_WIDTH-1:0];
	assign b_lo = rd_b_q[ENT_W-1:TIME_WIDTH];
	assign b_hi = rd_b_q[TIME_WIDTH-1:0];
	assign lo   = (a_lo > b_lo) ? a_lo : b_lo;
	assign hi   = (a_hi < b_hi) ? a_hi : b_hi;

	assign ptr_a_inc = ptr_a_q + CNT_W'(1);
	assign ptr_b_inc = ptr_b_q + CNT_W'(1);

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[cnt_a_q[IDX_W-1:0]] <= wdata;
		end
		if (wr_b) begin
			mem_b[cnt_b_q[IDX_W-1:0]] <= wdata;
		end
		rd_a_q <= mem_a[ptr_a_q[IDX_W-1:0]];
		rd_b_q <= mem_b[ptr_b_q[IDX_W-1:0]];
	end

	always_comb begin
		state_d    = state_q;
		cnt_a_d    = cnt_a_q;
		cnt_b_d    = cnt_b_q;
		ptr_a_d    = ptr_a_q;
		ptr_b_d    = ptr_b_q;
		pend_vld_d = pend_vld_q;
		pend_lo_d  = pend_lo_q;
		pend_hi_d  = pend_hi_q;
		strobe_d   = 1'b0;
		wr_a       = 1'b0;
		wr_b       = 1'b0;
		result_d   = '{kind: KIND_ACCEPT, out_start: '0, out_end: '0, last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.cmd)
						CMD_APPEND_A: begin
							strobe_d = 1'b1;
							if (cnt_a_q == CNT_W'(LIST_DEPTH)) begin
								result_d.kind = KIND_FULL;
							end else begin
								wr_a    = 1'b1;
								cnt_a_d = cnt_a_q + CNT_W'(1);
							end
						end
						CMD_APPEND_B: begin
							strobe_d = 1'b1;
							if (cnt_b_q == CNT_W'(LIST_DEPTH)) begin
								result_d.kind = KIND_FULL;
							end else begin
								wr_b    = 1'b1;
								cnt_b_d = cnt_b_q + CNT_W'(1);
							end
						end
						CMD_INTERSECT: begin
							if (cnt_a_q == '0 || cnt_b_q == '0) begin
								strobe_d      = 1'b1;
								result_d.kind = KIND_NONE;
							end else begin
								ptr_a_d    = '0;
								ptr_b_d    = '0;
								pend_vld_d = 1'b0;
								state_d    = ST_RD;
							end
						end
						CMD_CLEAR: begin
							strobe_d = 1'b1;
							cnt_a_d  = '0;
							cnt_b_d  = '0;
						end
						default: begin
							strobe_d = 1'b0;
						end
					endcase
				end
			end
			ST_RD: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				// hold each hit one step so the final one can carry last
				if (lo < hi) begin
					if (pend_vld_q) begin
						strobe_d           = 1'b1;
						result_d.kind      = KIND_ISECT;
						result_d.out_start = pend_lo_ext[FIELD_W-1:0];
						result_d.out_end   = pend_hi_ext[FIELD_W-1:0];
						result_d.last      = 1'b0;
					end
					pend_vld_d = 1'b1;
					pend_lo_d  = lo;
					pend_hi_d  = hi;
				end
				state_d = ST_RD;
				if (a_hi < b_hi) begin
					ptr_a_d = ptr_a_inc;
					if (ptr_a_inc >= cnt_a_q) begin
						state_d = ST_END;
					end
				end else begin
					ptr_b_d = ptr_b_inc;
					if (ptr_b_inc >= cnt_b_q) begin
						state_d = ST_END;
					end
				end
			end
			ST_END: begin
				strobe_d = 1'b1;
				if (pend_vld_q) begin
					result_d.kind      = KIND_ISECT;
					result_d.out_start = pend_lo_ext[FIELD_W-1:0];
					result_d.out_end   = pend_hi_ext[FIELD_W-1:0];
				end else begin
					result_d.kind = KIND_NONE;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_a_q    <= '0;
			cnt_b_q    <= '0;
			ptr_a_q    <= '0;
			ptr_b_q    <= '0;
			pend_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_a_q    <= cnt_a_d;
			cnt_b_q    <= cnt_b_d;
			ptr_a_q    <= ptr_a_d;
			ptr_b_q    <= ptr_b_d;
			pend_vld_q <= pend_vld_d;
			strobe_q   <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_lo_q <= pend_lo_d;
		pend_hi_q <= pend_hi_d;
		result_q  <= result_d;
	end

	a_single_beat_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.cmd != CMD_INTERSECT |=> strobe && result.last)
		else $error("append or clear did not give one final beat");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> ptr_a_q < cnt_a_q && ptr_b_q < cnt_b_q)
		else $error("walk pointer beyond list count");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_a || wr_b) |-> !busy)
		else $error("list write during walk");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.kind == KIND_NONE || result.kind == KIND_FULL) |-> result.last)
		else $error("status beat not marked last");

endmodule
